FILE: rtl/sd_card_spi_host_engine_defines.svh
// Assertion macros used by the engine's top module.
`ifndef SD_CARD_SPI_HOST_ENGINE_DEFINES_SVH
`define SD_CARD_SPI_HOST_ENGINE_DEFINES_SVH

// Asserts that a condition implies a consequence in the same cycle.
`define SDE_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define SDE_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sdhe_pkg.sv
`timescale 1ns / 1ps
package sdhe_pkg;
   localparam int unsigned BlockBytes    = 512;
   localparam int unsigned InitIdleBytes = 80;

   localparam logic [2:0] REQ_XCHG  = 3'd0;
   localparam logic [2:0] REQ_INIT  = 3'd1;
   localparam logic [2:0] REQ_READ1 = 3'd2;
   localparam logic [2:0] REQ_READN = 3'd3;
   localparam logic [2:0] REQ_WRITE = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ERR  = 2'd1;
   localparam logic [1:0] ST_TMO  = 2'd2;
   localparam logic [1:0] ST_BUSY = 2'd3;

   localparam logic [0:0] CSR_BUSY_TIMEOUT = 1'd0;
   localparam logic [0:0] CSR_POLL_LIMIT   = 1'd1;

   typedef enum logic [3:0] {
      PH_IDLE, PH_CLOCKS, PH_PRE, PH_FRAME, PH_R1, PH_ECHO, PH_TOKEN, PH_DATA,
      PH_CRC, PH_TAIL, PH_WDATA, PH_WCRC1, PH_WCRC2, PH_WRESP, PH_BUSY
   } phase_type;

   typedef struct packed {
      logic [7:0]  mosi_byte;
      logic        exchange_wanted;
      logic        select_active;
      logic        wants_write_data;
      logic        read_valid;
      logic [7:0]  read_data;
      logic        done_res;
      logic [1:0]  status;
      logic [1:0]  card_kind;
      logic        fast_clock;
      logic [31:0] capacity_blocks;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] start_sector;
      logic [15:0] block_count;
      logic [7:0]  miso_byte;
      logic [7:0]  write_byte;
   } req_type_s_type;
endpackage

FILE: rtl/sdhe_csd_decode.sv
`timescale 1ns / 1ps
module sdhe_csd_decode (
   input  logic [127:0] csd,
   output logic [31:0]  blocks
);
   logic [7:0]  c0, c5, c6, c7, c8, c9, c10;
   logic [3:0]  bl;
   logic [2:0]  ex;
   logic [11:0] cs1;
   logic [2:0]  mu;
   logic [21:0] cs2;
   logic [4:0]  sh;
   logic [12:0] cs1p;

   always_comb begin
      c0  = csd[127:120];
      c5  = csd[87:80];
      c6  = csd[79:72];
      c7  = csd[71:64];
      c8  = csd[63:56];
      c9  = csd[55:48];
      c10 = csd[47:40];
      bl  = c5[3:0];
      ex  = (bl > 4'd9) ? 3'(bl - 4'd9) : 3'd0;
      cs1 = {c6[1:0], c7, c8[7:6]};
      mu  = {c9[1:0], c10[7]};
      cs2 = {c7[5:0], c8, c9};
      sh  = 5'(mu) + 5'd2 + 5'(ex);
      cs1p = 13'(cs1) + 13'd1;
      if (c0[7:6] == 2'd0) begin
         blocks = 32'(cs1p) << sh;
      end else if (cs2 == 22'h3FFFFF) begin
         blocks = 32'hFFFF_FFFF;
      end else begin
         blocks = {cs2 + 22'd1, 10'd0};
      end
   end
endmodule

FILE: rtl/sdhe_core.sv
`timescale 1ns / 1ps
module sdhe_core #(
   parameter int unsigned INIT_IDLE_BYTES = sdhe_pkg::InitIdleBytes
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  sdhe_pkg::req_type_s_type req,
   input  logic [20:0]             busy_timeout,
   input  logic [7:0]              poll_limit,
   output sdhe_pkg::rsp_type       rsp
);
   import sdhe_pkg::*;

   localparam logic [7:0] C_GO_IDLE = 8'h40, C_IF_COND = 8'h48, C_CSD = 8'h49,
      C_STOP = 8'h4C, C_READ1 = 8'h51, C_READN = 8'h52, C_WRITE1 = 8'h58,
      C_APP = 8'h77, C_OPCOND = 8'h69;
   localparam logic [9:0] IdleLast = 10'(INIT_IDLE_BYTES);

   phase_type   phase_ff, phase_in;
   logic [47:0] frame_ff, frame_in;
   logic [9:0]  cnt_ff, cnt_in;
   logic [20:0] wait_ff, wait_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] total_ff, total_in;
   logic [15:0] left_ff, left_in;
   logic [31:0] sector_ff, sector_in;
   logic [127:0] csd_ff, csd_in;
   logic        sel_ff, sel_in, fast_ff, fast_in, echo_ff, echo_in;
   logic [31:0] csd_blocks;
   logic [7:0]  o_mosi, o_rdata, m, cmd;
   logic        o_want, o_wdata, o_rvalid, o_done;
   logic [1:0]  o_status;
   logic [20:0] wait_inc, tmo;
   logic        timed_out;
   logic [7:0]  plim;
   logic [9:0]  cnt_inc;

   sdhe_csd_decode u_csd (.csd(csd_ff), .blocks(csd_blocks));

   function automatic logic [31:0] addr_of(input logic [1:0] k, input logic [31:0] s);
      return (k == 2'd2) ? s : (s << $clog2(BlockBytes));
   endfunction

   always_comb begin
      phase_in = phase_ff; frame_in = frame_ff; cnt_in = cnt_ff; wait_in = wait_ff;
      kind_in = kind_ff; total_in = total_ff; left_in = left_ff; sector_in = sector_ff;
      csd_in = csd_ff; sel_in = sel_ff; fast_in = fast_ff; echo_in = echo_ff;
      o_mosi = 8'hFF; o_want = 1'b0; o_wdata = 1'b0; o_rvalid = 1'b0; o_rdata = 8'h00;
      o_done = 1'b0; o_status = ST_OK;
      m = req.miso_byte;
      cmd = frame_ff[47:40];
      cnt_inc = cnt_ff + 10'd1;
      wait_inc = wait_ff + 21'd1;
      tmo = (busy_timeout == 21'd0) ? 21'd1 : busy_timeout;
      timed_out = wait_inc >= tmo;
      plim = (poll_limit == 8'd0) ? 8'd1 : poll_limit;

      // Actions are coded through small macro-like sequences written inline.
      if (req.req_type == REQ_INIT) begin
         kind_in = 2'd0; fast_in = 1'b0; total_in = '0; sel_in = 1'b0;
         phase_in = PH_CLOCKS; cnt_in = '0;
         o_mosi = 8'hFF; o_want = 1'b1; o_status = ST_BUSY;
      end else if (req.req_type == REQ_READ1 || req.req_type == REQ_READN ||
                   req.req_type == REQ_WRITE) begin
         sector_in = req.start_sector;
         if (req.req_type != REQ_READ1) left_in = req.block_count;
         if (req.req_type == REQ_WRITE && req.block_count == 16'd0) begin
            phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_status = ST_OK;
         end else begin
            frame_in = {(req.req_type == REQ_READ1) ? C_READ1 :
                        (req.req_type == REQ_READN) ? C_READN : C_WRITE1,
                        addr_of(kind_ff, req.start_sector), 8'h01};
            sel_in = 1'b1; cnt_in = '0; phase_in = PH_PRE;
            o_mosi = 8'hFF; o_want = 1'b1; o_status = ST_BUSY;
         end
      end else if (phase_ff != PH_IDLE) begin
         o_want = 1'b1; o_status = ST_BUSY; o_mosi = 8'hFF;
         case (phase_ff)
            PH_CLOCKS: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= IdleLast) begin
                  frame_in = {C_GO_IDLE, 32'd0, 8'h95}; sel_in = 1'b1;
                  cnt_in = '0; phase_in = PH_FRAME; o_mosi = C_GO_IDLE;
               end
            end
            PH_PRE: begin
               phase_in = PH_FRAME; cnt_in = '0; o_mosi = frame_ff[47:40];
            end
            PH_FRAME: begin
               cnt_in = cnt_inc;
               case (cnt_inc[2:0])
                  3'd1: o_mosi = frame_ff[39:32];
                  3'd2: o_mosi = frame_ff[31:24];
                  3'd3: o_mosi = frame_ff[23:16];
                  3'd4: o_mosi = frame_ff[15:8];
                  3'd5: o_mosi = frame_ff[7:0];
                  default: begin
                     phase_in = PH_R1; cnt_in = '0;
                  end
               endcase
            end
            PH_R1: begin
               cnt_in = cnt_inc;
               if (!m[7] || cnt_inc >= 10'(plim)) begin
                  if (cmd == C_GO_IDLE) begin
                     sel_in = 1'b0;
                     if (m != 8'd1) begin
                        phase_in = PH_IDLE; o_done = 1'b1; o_status = ST_ERR; o_want = 1'b0;
                     end else begin
                        frame_in = {C_IF_COND, 32'h1AA, 8'h87}; sel_in = 1'b1;
                        cnt_in = '0; phase_in = PH_FRAME; o_mosi = C_IF_COND;
                     end
                  end else if (cmd == C_IF_COND) begin
                     if (m == 8'd1) begin
                        phase_in = PH_ECHO; cnt_in = '0; echo_in = 1'b1;
                     end else begin
                        kind_in = 2'd1; wait_in = '0;
                        frame_in = {C_APP, 32'd0, 8'h01}; sel_in = 1'b1;
                        cnt_in = '0; phase_in = PH_PRE;
                     end
                  end else if ((cmd == C_APP && m <= 8'd1)) begin
                     frame_in = {C_OPCOND, (kind_ff == 2'd2) ? 32'h4000_0000 : 32'd0, 8'h01};
                     sel_in = 1'b1; cnt_in = '0; phase_in = PH_FRAME; o_mosi = C_OPCOND;
                  end else if (cmd == C_APP || cmd == C_OPCOND) begin
                     if (m == 8'd0) begin
                        fast_in = 1'b1;
                        frame_in = {C_CSD, 32'd0, 8'h01}; sel_in = 1'b1;
                        cnt_in = '0; phase_in = PH_PRE;
                     end else begin
                        wait_in = wait_inc;
                        if (timed_out) begin
                           phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1;
                           o_status = ST_TMO; o_want = 1'b0;
                        end else begin
                           frame_in = {C_APP, 32'd0, 8'h01}; sel_in = 1'b1;
                           cnt_in = '0; phase_in = PH_PRE;
                        end
                     end
                  end else if (cmd == C_CSD || cmd == C_READ1 ||
                               (cmd == C_READN && left_ff != 16'd0)) begin
                     if (m != 8'd0) begin
                        if (cmd == C_CSD) total_in = '0;
                        phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                        o_status = (cmd == C_CSD) ? ST_OK : ST_ERR;
                     end else begin
                        phase_in = PH_TOKEN; wait_in = '0;
                     end
                  end else if (cmd == C_READN) begin
                     if (m != 8'd0) begin
                        phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                        o_status = ST_ERR;
                     end else begin
                        frame_in = {C_STOP, 32'd0, 8'h01}; sel_in = 1'b1;
                        cnt_in = '0; phase_in = PH_PRE;
                     end
                  end else if (cmd == C_WRITE1) begin
                     if (m != 8'd0) begin
                        phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                        o_status = ST_ERR;
                     end else begin
                        phase_in = PH_WDATA; cnt_in = '0; o_mosi = 8'hFE; o_wdata = 1'b1;
                     end
                  end else if (cmd == C_STOP) begin
                     phase_in = PH_TAIL;
                  end else begin
                     phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                     o_status = ST_ERR;
                  end
               end
            end
            PH_ECHO: begin
               if ((cnt_ff == 10'd2 && m != 8'h01) || (cnt_ff == 10'd3 && m != 8'hAA))
                  echo_in = 1'b0;
               cnt_in = cnt_inc;
               if (cnt_inc >= 10'd4) begin
                  sel_in = 1'b0;
                  if (!echo_in) begin
                     phase_in = PH_IDLE; o_done = 1'b1; o_want = 1'b0; o_status = ST_ERR;
                  end else begin
                     kind_in = 2'd2; wait_in = '0;
                     frame_in = {C_APP, 32'd0, 8'h01}; sel_in = 1'b1;
                     cnt_in = '0; phase_in = PH_PRE;
                  end
               end
            end
            PH_TOKEN: begin
               if (m == 8'hFE) begin
                  phase_in = PH_DATA; cnt_in = '0;
               end else if (m == 8'hFF && !timed_out) begin
                  wait_in = wait_inc;
               end else begin
                  wait_in = (m == 8'hFF) ? wait_inc : wait_ff;
                  if (cmd == C_CSD) total_in = '0;
                  phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                  o_status = (cmd == C_CSD) ? ST_OK : ST_TMO;
               end
            end
            PH_DATA: begin
               cnt_in = cnt_inc;
               if (cmd == C_CSD) begin
                  csd_in = {csd_ff[119:0], m};
                  if (cnt_inc >= 10'd16) begin
                     phase_in = PH_CRC; cnt_in = '0;
                  end
               end else begin
                  o_rvalid = 1'b1; o_rdata = m;
                  if (cnt_ff == 10'(BlockBytes - 1)) begin
                     phase_in = PH_CRC; cnt_in = '0;
                  end
               end
            end
            PH_CRC: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= 10'd2) begin
                  if (cmd == C_CSD) begin
                     total_in = csd_blocks;
                     phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                     o_status = ST_OK;
                  end else if (cmd == C_READN) begin
                     left_in = left_ff - 16'd1;
                     if (left_in != 16'd0) begin
                        phase_in = PH_TOKEN; wait_in = '0;
                     end else begin
                        frame_in = {C_STOP, 32'd0, 8'h01}; sel_in = 1'b1;
                        cnt_in = '0; phase_in = PH_PRE;
                     end
                  end else begin
                     phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                     o_status = ST_OK;
                  end
               end
            end
            PH_TAIL: begin
               phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
               o_status = ST_OK;
            end
            PH_WDATA: begin
               if (cnt_ff < 10'(BlockBytes)) begin
                  o_mosi = req.write_byte; cnt_in = cnt_inc;
                  o_wdata = (cnt_inc < 10'(BlockBytes));
               end else begin
                  phase_in = PH_WCRC1;
               end
            end
            PH_WCRC1: phase_in = PH_WCRC2;
            PH_WCRC2: phase_in = PH_WRESP;
            PH_WRESP: begin
               if (m[4:0] != 5'h05) begin
                  phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                  o_status = ST_ERR;
               end else begin
                  phase_in = PH_BUSY; wait_in = '0;
               end
            end
            PH_BUSY: begin
               if (m == 8'hFF) begin
                  left_in = left_ff - 16'd1;
                  sector_in = sector_ff + 32'd1;
                  if (left_in == 16'd0) begin
                     phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                     o_status = ST_OK;
                  end else begin
                     frame_in = {C_WRITE1, addr_of(kind_ff, sector_in), 8'h01};
                     sel_in = 1'b1; cnt_in = '0; phase_in = PH_PRE;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (timed_out) begin
                     phase_in = PH_IDLE; sel_in = 1'b0; o_done = 1'b1; o_want = 1'b0;
                     o_status = ST_ERR;
                  end
               end
            end
            default: begin
               o_want = 1'b0; o_status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; frame_ff <= '0; cnt_ff <= '0; wait_ff <= '0;
         kind_ff <= '0; total_ff <= '0; left_ff <= '0; sector_ff <= '0;
         sel_ff <= 1'b0; fast_ff <= 1'b0; echo_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; frame_ff <= frame_in; cnt_ff <= cnt_in; wait_ff <= wait_in;
         kind_ff <= kind_in; total_ff <= total_in; left_ff <= left_in;
         sector_ff <= sector_in; sel_ff <= sel_in; fast_ff <= fast_in; echo_ff <= echo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) csd_ff <= csd_in;
   end

   always_comb begin
      rsp.mosi_byte        = o_mosi;
      rsp.exchange_wanted  = o_want;
      rsp.select_active    = o_want & sel_in;
      rsp.wants_write_data = o_wdata;
      rsp.read_valid       = o_rvalid;
      rsp.read_data        = o_rdata;
      rsp.done_res         = o_done;
      rsp.status           = o_status;
      rsp.card_kind        = kind_in;
      rsp.fast_clock       = fast_in;
      rsp.capacity_blocks  = total_in;
   end
endmodule

FILE: rtl/sd_card_spi_host_engine.sv
`timescale 1ns / 1ps
// An accepted transaction has its result registered in the single result register,
// the only stage; one transaction per cycle is taken unless rsp_ready holds it off.
// The input is taken whenever the result register is empty or being drained.
// Reset (synchronous, active high) returns to idle, no card type, timeout 1048576,
// poll limit 8 and no result pending.
`include "sd_card_spi_host_engine_defines.svh"
module sd_card_spi_host_engine #(
   parameter int unsigned INIT_IDLE_BYTES = sdhe_pkg::InitIdleBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_start_sector,
   input  logic [15:0] req_block_count,
   input  logic [7:0]  req_miso_byte,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_mosi_byte,
   output logic        rsp_exchange_wanted,
   output logic        rsp_select_active,
   output logic        rsp_wants_write_data,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_card_kind,
   output logic        rsp_fast_clock,
   output logic [31:0] rsp_capacity_blocks,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_write_data
);
   import sdhe_pkg::*;

   logic           step;
   req_type_s_type req;
   rsp_type        rsp_in, rsp_ff;
   logic           valid_ff;
   logic [20:0]    tmo_ff;
   logic [7:0]     plim_ff;

   assign req_ready = !valid_ff || rsp_ready;
   assign step = req_valid && req_ready;
   assign req = '{req_type: req_type, start_sector: req_start_sector,
                  block_count: req_block_count, miso_byte: req_miso_byte,
                  write_byte: req_write_byte};

   sdhe_core #(.INIT_IDLE_BYTES(INIT_IDLE_BYTES)) u_core (
      .clock(clock), .reset(reset), .step(step), .req(req),
      .busy_timeout(tmo_ff), .poll_limit(plim_ff), .rsp(rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tmo_ff   <= 21'h100000;
         plim_ff  <= 8'd8;
      end else begin
         if (step) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
         if (csr_write_enable && csr_index == CSR_BUSY_TIMEOUT) tmo_ff <= csr_write_data;
         if (csr_write_enable && csr_index == CSR_POLL_LIMIT) plim_ff <= csr_write_data[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (step) rsp_ff <= rsp_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_mosi_byte        = rsp_ff.mosi_byte;
   assign rsp_exchange_wanted  = rsp_ff.exchange_wanted;
   assign rsp_select_active    = rsp_ff.select_active;
   assign rsp_wants_write_data = rsp_ff.wants_write_data;
   assign rsp_read_valid       = rsp_ff.read_valid;
   assign rsp_read_data        = rsp_ff.read_data;
   assign rsp_done_res         = rsp_ff.done_res;
   assign rsp_status           = rsp_ff.status;
   assign rsp_card_kind        = rsp_ff.card_kind;
   assign rsp_fast_clock       = rsp_ff.fast_clock;
   assign rsp_capacity_blocks  = rsp_ff.capacity_blocks;

   `SDE_ASSERT_NEXT(a_step_gives_result, clock, reset, step, rsp_valid, "accepted transaction gave no result")
   `SDE_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, rsp_status != ST_BUSY && !rsp_exchange_wanted, "finished result still busy")
   `SDE_ASSERT_IMP(a_want_busy, clock, reset, rsp_valid && rsp_exchange_wanted, rsp_status == ST_BUSY, "exchange wanted without busy status")
   `SDE_ASSERT_IMP(a_select_needs_want, clock, reset, rsp_valid && rsp_select_active, rsp_exchange_wanted, "select active without exchange")
endmodule

FILE: tb/sd_card_spi_host_engine_scoreboard.sv
`timescale 1ns / 1ps
module sd_card_spi_host_engine_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_start_sector,
   input  logic [15:0] req_block_count,
   input  logic [7:0]  req_miso_byte,
   input  logic [7:0]  req_write_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_mosi_byte,
   input  logic        rsp_exchange_wanted,
   input  logic        rsp_select_active,
   input  logic        rsp_wants_write_data,
   input  logic        rsp_read_valid,
   input  logic [7:0]  rsp_read_data,
   input  logic        rsp_done_res,
   input  logic [1:0]  rsp_status,
   input  logic [1:0]  rsp_card_kind,
   input  logic        rsp_fast_clock,
   input  logic [31:0] rsp_capacity_blocks,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_write_data,
   output int          outstanding,
   output int          mismatches
);
   import sdhe_pkg::*;

   localparam logic [7:0] CMD_GO_IDLE      = 8'h40;
   localparam logic [7:0] CMD_IF_COND      = 8'h48;
   localparam logic [7:0] CMD_SEND_CSD     = 8'h49;
   localparam logic [7:0] CMD_STOP         = 8'h4C;
   localparam logic [7:0] CMD_READ_SINGLE  = 8'h51;
   localparam logic [7:0] CMD_READ_MULTI   = 8'h52;
   localparam logic [7:0] CMD_WRITE_SINGLE = 8'h58;
   localparam logic [7:0] CMD_APP          = 8'h77;
   localparam logic [7:0] CMD_OPCOND       = 8'h69;

   int unsigned timeout_limit;
   int unsigned poll_limit;
   phase_type   ph;
   logic [47:0] frame;
   int unsigned bcount;
   int unsigned waited;
   logic [1:0]  card_kind;
   logic [31:0] capacity;
   logic [15:0] blocks_left;
   logic [31:0] sector;
   logic [7:0]  csd [16];
   logic        sel;
   logic        fast;
   logic        echo_good;
   rsp_type     nxt;
   rsp_type     pending_replies [$];

   initial begin
      outstanding = 0;
      mismatches = 0;
   end

   function void clear_state();
      timeout_limit = 1048576;
      poll_limit = 8;
      ph = PH_IDLE;
      frame = '0;
      bcount = 0;
      waited = 0;
      card_kind = 2'd0;
      capacity = '0;
      blocks_left = '0;
      sector = '0;
      foreach (csd[i]) csd[i] = 8'h00;
      sel = 1'b0;
      fast = 1'b0;
      echo_good = 1'b0;
   endfunction

   function void send_byte(input logic [7:0] b);
      nxt.mosi_byte = b;
      nxt.exchange_wanted = 1'b1;
      nxt.status = ST_BUSY;
   endfunction

   function void conclude(input logic [1:0] st);
      ph = PH_IDLE;
      sel = 1'b0;
      nxt.mosi_byte = 8'hFF;
      nxt.exchange_wanted = 1'b0;
      nxt.wants_write_data = 1'b0;
      nxt.done_res = 1'b1;
      nxt.status = st;
   endfunction

   function logic [7:0] frame_byte(input int unsigned i);
      return frame[47 - 8 * (i % 6) -: 8];
   endfunction

   function logic [31:0] block_addr(input logic [31:0] s);
      return (card_kind == 2'd2) ? s : {s[22:0], 9'd0};
   endfunction

   function void begin_cmd(input logic [7:0] cmd, input logic [31:0] arg,
                           input logic [7:0] crc, input bit pre);
      frame = {cmd, arg, crc};
      sel = 1'b1;
      bcount = 0;
      if (pre) begin
         ph = PH_PRE;
         send_byte(8'hFF);
      end else begin
         ph = PH_FRAME;
         send_byte(cmd);
      end
   endfunction

   function void await_token();
      ph = PH_TOKEN;
      waited = 0;
      send_byte(8'hFF);
   endfunction

   function bit expired();
      waited++;
      return waited >= timeout_limit;
   endfunction

   function void opcond_retry(input logic [7:0] r);
      sel = 1'b0;
      if (r == 8'h00) begin
         fast = 1'b1;
         begin_cmd(CMD_SEND_CSD, 32'd0, 8'h01, 1'b1);
      end else if (expired()) begin
         conclude(ST_TMO);
      end else begin
         begin_cmd(CMD_APP, 32'd0, 8'h01, 1'b1);
      end
   endfunction

   function void decode_capacity();
      logic [31:0] size_field;
      logic [31:0] read_len;
      logic [31:0] extra;
      logic [31:0] mult;
      if (csd[0][7:6] == 2'd0) begin
         read_len = {28'd0, csd[5][3:0]};
         extra = (read_len > 9) ? read_len - 9 : 0;
         size_field = {20'd0, csd[6][1:0], csd[7], csd[8][7:6]};
         mult = {29'd0, csd[9][1:0], csd[10][7]};
         capacity = (size_field + 1) << (mult + 2 + extra);
      end else begin
         size_field = {10'd0, csd[7][5:0], csd[8], csd[9]};
         capacity = (size_field == 32'h003F_FFFF) ? 32'hFFFF_FFFF : (size_field + 1) << 10;
      end
   endfunction

   function void take_r1(input logic [7:0] r);
      case (frame[47:40])
         CMD_GO_IDLE: begin
            sel = 1'b0;
            if (r != 8'h01) conclude(ST_ERR);
            else begin_cmd(CMD_IF_COND, 32'h0000_01AA, 8'h87, 1'b0);
         end
         CMD_IF_COND: begin
            if (r == 8'h01) begin
               ph = PH_ECHO;
               bcount = 0;
               echo_good = 1'b1;
               send_byte(8'hFF);
            end else begin
               sel = 1'b0;
               card_kind = 2'd1;
               waited = 0;
               begin_cmd(CMD_APP, 32'd0, 8'h01, 1'b1);
            end
         end
         CMD_APP: begin
            if (r <= 8'h01)
               begin_cmd(CMD_OPCOND, (card_kind == 2'd2) ? 32'h4000_0000 : 32'd0, 8'h01, 1'b0);
            else
               opcond_retry(r);
         end
         CMD_OPCOND: opcond_retry(r);
         CMD_SEND_CSD: begin
            if (r != 8'h00) begin
               capacity = '0;
               conclude(ST_OK);
            end else begin
               await_token();
            end
         end
         CMD_READ_SINGLE: begin
            if (r != 8'h00) conclude(ST_ERR);
            else await_token();
         end
         CMD_READ_MULTI: begin
            if (r != 8'h00) conclude(ST_ERR);
            else if (blocks_left == 16'd0) begin_cmd(CMD_STOP, 32'd0, 8'h01, 1'b1);
            else await_token();
         end
         CMD_WRITE_SINGLE: begin
            if (r != 8'h00) begin
               conclude(ST_ERR);
            end else begin
               ph = PH_WDATA;
               bcount = 0;
               send_byte(8'hFE);
               nxt.wants_write_data = 1'b1;
            end
         end
         CMD_STOP: begin
            ph = PH_TAIL;
            send_byte(8'hFF);
         end
         default: conclude(ST_ERR);
      endcase
   endfunction

   function void finish_block();
      if (frame[47:40] == CMD_SEND_CSD) begin
         decode_capacity();
         conclude(ST_OK);
      end else if (frame[47:40] == CMD_READ_MULTI) begin
         blocks_left = blocks_left - 16'd1;
         if (blocks_left != 16'd0) await_token();
         else begin_cmd(CMD_STOP, 32'd0, 8'h01, 1'b1);
      end else begin
         conclude(ST_OK);
      end
   endfunction

   function void advance(input logic [7:0] m, input logic [7:0] wb);
      int unsigned len;
      len = (frame[47:40] == CMD_SEND_CSD) ? 16 : BlockBytes;
      case (ph)
         PH_CLOCKS: begin
            bcount++;
            if (bcount < InitIdleBytes) send_byte(8'hFF);
            else begin_cmd(CMD_GO_IDLE, 32'd0, 8'h95, 1'b0);
         end
         PH_PRE: begin
            ph = PH_FRAME;
            bcount = 0;
            send_byte(frame_byte(0));
         end
         PH_FRAME: begin
            bcount++;
            if (bcount < 6) begin
               send_byte(frame_byte(bcount));
            end else begin
               ph = PH_R1;
               bcount = 0;
               send_byte(8'hFF);
            end
         end
         PH_R1: begin
            bcount++;
            if (!m[7] || bcount >= poll_limit) take_r1(m);
            else send_byte(8'hFF);
         end
         PH_ECHO: begin
            if ((bcount == 2 && m != 8'h01) || (bcount == 3 && m != 8'hAA)) echo_good = 1'b0;
            bcount++;
            if (bcount < 4) begin
               send_byte(8'hFF);
            end else begin
               sel = 1'b0;
               if (!echo_good) begin
                  conclude(ST_ERR);
               end else begin
                  card_kind = 2'd2;
                  waited = 0;
                  begin_cmd(CMD_APP, 32'd0, 8'h01, 1'b1);
               end
            end
         end
         PH_TOKEN: begin
            if (m == 8'hFE) begin
               ph = PH_DATA;
               bcount = 0;
               send_byte(8'hFF);
            end else if (m == 8'hFF && !expired()) begin
               send_byte(8'hFF);
            end else if (frame[47:40] == CMD_SEND_CSD) begin
               capacity = '0;
               conclude(ST_OK);
            end else begin
               conclude(ST_TMO);
            end
         end
         PH_DATA: begin
            if (len == 16) begin
               csd[bcount % 16] = m;
            end else begin
               nxt.read_valid = 1'b1;
               nxt.read_data = m;
            end
            bcount++;
            if (bcount >= len) begin
               ph = PH_CRC;
               bcount = 0;
            end
            send_byte(8'hFF);
         end
         PH_CRC: begin
            bcount++;
            if (bcount < 2) send_byte(8'hFF);
            else finish_block();
         end
         PH_TAIL: conclude(ST_OK);
         PH_WDATA: begin
            if (bcount < BlockBytes) begin
               send_byte(wb);
               bcount++;
               nxt.wants_write_data = (bcount < BlockBytes);
            end else begin
               ph = PH_WCRC1;
               send_byte(8'hFF);
            end
         end
         PH_WCRC1: begin
            ph = PH_WCRC2;
            send_byte(8'hFF);
         end
         PH_WCRC2: begin
            ph = PH_WRESP;
            send_byte(8'hFF);
         end
         PH_WRESP: begin
            if (m[4:0] != 5'h05) begin
               conclude(ST_ERR);
            end else begin
               ph = PH_BUSY;
               waited = 0;
               send_byte(8'hFF);
            end
         end
         PH_BUSY: begin
            if (m == 8'hFF) begin
               sel = 1'b0;
               blocks_left = blocks_left - 16'd1;
               sector = sector + 32'd1;
               if (blocks_left == 16'd0) conclude(ST_OK);
               else begin_cmd(CMD_WRITE_SINGLE, block_addr(sector), 8'h01, 1'b1);
            end else if (expired()) begin
               conclude(ST_ERR);
            end else begin
               send_byte(8'hFF);
            end
         end
         default: ;
      endcase
   endfunction

   function rsp_type predict_reply(input logic [2:0] kind, input logic [31:0] start,
                                   input logic [15:0] count, input logic [7:0] m,
                                   input logic [7:0] wb);
      nxt = '0;
      nxt.mosi_byte = 8'hFF;
      nxt.status = ST_OK;
      case (kind)
         REQ_INIT: begin
            card_kind = 2'd0;
            fast = 1'b0;
            capacity = '0;
            sel = 1'b0;
            ph = PH_CLOCKS;
            bcount = 0;
            send_byte(8'hFF);
         end
         REQ_READ1: begin
            sector = start;
            begin_cmd(CMD_READ_SINGLE, block_addr(start), 8'h01, 1'b1);
         end
         REQ_READN: begin
            sector = start;
            blocks_left = count;
            begin_cmd(CMD_READ_MULTI, block_addr(start), 8'h01, 1'b1);
         end
         REQ_WRITE: begin
            sector = start;
            blocks_left = count;
            if (count == 16'd0) conclude(ST_OK);
            else begin_cmd(CMD_WRITE_SINGLE, block_addr(start), 8'h01, 1'b1);
         end
         default: if (ph != PH_IDLE) advance(m, wb);
      endcase
      nxt.select_active = nxt.exchange_wanted && sel;
      nxt.card_kind = card_kind;
      nxt.fast_clock = fast;
      nxt.capacity_blocks = capacity;
      return nxt;
   endfunction

   task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("%0t mismatch: %s", $realtime, what);
   endtask

   task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   task compare_reply();
      rsp_type want;
      if (pending_replies.size() == 0) begin
         report_mismatch("response arrived with no transaction pending");
      end else begin
         want = pending_replies.pop_front();
         check_field("mosi_byte", rsp_mosi_byte, want.mosi_byte);
         check_field("exchange_wanted", rsp_exchange_wanted, want.exchange_wanted);
         check_field("select_active", rsp_select_active, want.select_active);
         check_field("wants_write_data", rsp_wants_write_data, want.wants_write_data);
         check_field("read_valid", rsp_read_valid, want.read_valid);
         check_field("read_data", rsp_read_data, want.read_data);
         check_field("done_res", rsp_done_res, want.done_res);
         check_field("status", rsp_status, want.status);
         check_field("card_kind", rsp_card_kind, want.card_kind);
         check_field("fast_clock", rsp_fast_clock, want.fast_clock);
         check_field("capacity_blocks", rsp_capacity_blocks, want.capacity_blocks);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         pending_replies.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_BUSY_TIMEOUT) timeout_limit = csr_write_data;
            else poll_limit = csr_write_data[7:0];
         end
         if (rsp_valid && rsp_ready) compare_reply();
         if (req_valid && req_ready)
            pending_replies.push_back(predict_reply(req_type, req_start_sector,
               req_block_count, req_miso_byte, req_write_byte));
      end
      outstanding <= pending_replies.size();
   end
endmodule

FILE: tb/sd_card_spi_host_engine_test.sv
`timescale 1ns / 1ps
module sd_card_spi_host_engine_test;
   import sdhe_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = REQ_XCHG;
   logic [31:0] req_start_sector = '0;
   logic [15:0] req_block_count = '0;
   logic [7:0]  req_miso_byte = 8'hFF;
   logic [7:0]  req_write_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_mosi_byte;
   logic        rsp_exchange_wanted;
   logic        rsp_select_active;
   logic        rsp_wants_write_data;
   logic        rsp_read_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_done_res;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_card_kind;
   logic        rsp_fast_clock;
   logic [31:0] rsp_capacity_blocks;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = CSR_BUSY_TIMEOUT;
   logic [20:0] csr_write_data = '0;
   int          outstanding;
   int          mismatches;

   req_type_s_type stim_q [$];
   int unsigned    cur_busy = 1048576;
   int unsigned    cur_poll = 8;
   int             send_pct = 0;
   int             rsp_pct = 0;
   int             items_sent = 0;
   int             sequences = 0;

   sd_card_spi_host_engine uut (.*);
   sd_card_spi_host_engine_scoreboard scoreboard (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[sd_card_spi_host_engine] ERROR");
      $finish;
   end

   always @(posedge clock) rsp_ready <= !reset && ($urandom_range(99) >= rsp_pct);

   function automatic int unsigned lower_of(input int unsigned a, input int unsigned b);
      return (a < b) ? a : b;
   endfunction

   task automatic put(input logic [2:0] t, input logic [31:0] s, input logic [15:0] c,
                      input logic [7:0] m, input logic [7:0] w);
      req_type_s_type it;
      it.req_type = t;
      it.start_sector = s;
      it.block_count = c;
      it.miso_byte = m;
      it.write_byte = w;
      stim_q.push_back(it);
   endtask

   task automatic exchange_item(input logic [7:0] m);
      put(REQ_XCHG, $urandom, $urandom, m, $urandom);
   endtask

   // A command frame followed by a short R1 poll; now and then the R1 is corrupted.
   task automatic command_reply(input bit pre, input logic [7:0] r1);
      int unsigned polls;
      logic [7:0]  answer;
      polls = $urandom_range(lower_of(cur_poll - 1, 3), 0);
      answer = ($urandom_range(99) < 3) ? 8'($urandom) : r1;
      if (pre) exchange_item($urandom);
      repeat (6) exchange_item($urandom);
      repeat (polls) exchange_item(8'h80 | 8'($urandom));
      exchange_item(answer);
   endtask

   task automatic token_then_data(input int n);
      int unsigned gap;
      gap = $urandom_range(lower_of(cur_busy - 1, 6), 0);
      repeat (gap) exchange_item(8'hFF);
      exchange_item(($urandom_range(99) < 3) ? 8'($urandom) : 8'hFE);
      repeat (n + 2) exchange_item($urandom);
   endtask

   task automatic card_init();
      int unsigned retries;
      int unsigned gap;
      bit          saturate;
      put(REQ_INIT, $urandom, $urandom, $urandom, $urandom);
      repeat (InitIdleBytes) exchange_item($urandom);
      command_reply(1'b0, 8'h01);
      if ($urandom_range(9) < 7) begin
         command_reply(1'b0, 8'h01);
         exchange_item($urandom);
         exchange_item($urandom);
         exchange_item(8'h01);
         exchange_item(8'hAA);
      end else begin
         command_reply(1'b0, 8'h05);
      end
      retries = $urandom_range(lower_of(cur_busy - 1, 2), 0);
      repeat (retries) begin
         command_reply(1'b1, 8'h01);
         command_reply(1'b0, 8'h01);
      end
      command_reply(1'b1, 8'h01);
      command_reply(1'b0, 8'h00);
      command_reply(1'b1, 8'h00);
      gap = $urandom_range(lower_of(cur_busy - 1, 6), 0);
      repeat (gap) exchange_item(8'hFF);
      exchange_item(8'hFE);
      saturate = ($urandom_range(4) == 0);
      for (int i = 0; i < 16; i++) begin
         if (saturate && i == 0) exchange_item(8'h40);
         else if (saturate && i == 7) exchange_item(8'h3F | 8'($urandom));
         else if (saturate && (i == 8 || i == 9)) exchange_item(8'hFF);
         else exchange_item($urandom);
      end
      repeat (2) exchange_item($urandom);
   endtask

   task automatic write_blocks(input int n);
      int unsigned gap;
      put(REQ_WRITE, $urandom, 16'(n), $urandom, $urandom);
      repeat (n) begin
         command_reply(1'b1, 8'h00);
         repeat (BlockBytes + 3) exchange_item($urandom);
         exchange_item(($urandom_range(99) < 3) ? 8'($urandom) : {3'($urandom), 5'h05});
         gap = $urandom_range(lower_of(cur_busy - 1, 4), 0);
         repeat (gap) exchange_item(8'($urandom_range(254, 0)));
         exchange_item(8'hFF);
      end
   endtask

   // Long sequences are picked only when the remaining room can hold them.
   task automatic add_sequence(input int room);
      int unsigned pick;
      int          n;
      pick = $urandom_range(99);
      if (room < 600 && ((pick >= 18 && pick < 38) || (pick >= 50 && pick < 66)))
         pick = 66 + pick % 34;
      if (room < 100 && pick < 18) pick = 82 + pick;
      sequences++;
      if (pick < 18) begin
         card_init();
      end else if (pick < 38) begin
         put(REQ_READ1, $urandom, $urandom, $urandom, $urandom);
         command_reply(1'b1, 8'h00);
         token_then_data(BlockBytes);
      end else if (pick < 50) begin
         n = (room < 600) ? 0 : $urandom_range(2, 0);
         put(REQ_READN, $urandom, 16'(n), $urandom, $urandom);
         command_reply(1'b1, 8'h00);
         repeat (n) token_then_data(BlockBytes);
         command_reply(1'b1, 8'($urandom_range(127, 0)));
         exchange_item($urandom);
      end else if (pick < 66) begin
         write_blocks($urandom_range(2, 1));
      end else if (pick < 72) begin
         put(REQ_WRITE, $urandom, 16'd0, $urandom, $urandom);
      end else if (pick < 82) begin
         put(pick[0] ? REQ_READN : REQ_WRITE, $urandom, $urandom, $urandom, $urandom);
         command_reply(1'b1, 8'($urandom_range(127, 1)));
      end else begin
         repeat ($urandom_range(8, 1))
            put(3'($urandom_range(7, 0)), $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic add_directed();
      put(REQ_XCHG, 32'd0, 16'd0, 8'hFF, 8'h00);
      put(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 8'hFF);
      put(3'd6, 32'h0000_0000, 16'h0000, 8'hFF, 8'h00);
      put(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 8'hFF);
      put(REQ_WRITE, 32'hFFFF_FFFF, 16'd0, 8'h00, 8'h00);
      put(REQ_READ1, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);
      repeat (7) exchange_item($urandom);
      exchange_item(8'h04);
      put(REQ_READN, 32'd0, 16'hFFFF, 8'h00, 8'h00);
      repeat (3) exchange_item($urandom);
      // A new request while another is still running abandons the first one.
      put(REQ_INIT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);
      repeat (2) exchange_item($urandom);
      put(REQ_WRITE, 32'h1234_5678, 16'd1, 8'h00, 8'h00);
      exchange_item($urandom);
   endtask

   task automatic set_regs(input int unsigned busy, input int unsigned poll);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_BUSY_TIMEOUT;
      csr_write_data <= 21'(busy);
      @(posedge clock);
      csr_index <= CSR_POLL_LIMIT;
      csr_write_data <= 21'(poll);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_busy = busy;
      cur_poll = poll;
   endtask

   task automatic send_item(input req_type_s_type it);
      if ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      req_valid <= 1'b1;
      req_type <= it.req_type;
      req_start_sector <= it.start_sector;
      req_block_count <= it.block_count;
      req_miso_byte <= it.miso_byte;
      req_write_byte <= it.write_byte;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Each phase starts only after every outstanding response has been drained.
   task automatic run_phase(input bit directed, input int unsigned busy,
                            input int unsigned poll, input int spct, input int rpct,
                            input int budget);
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      set_regs(busy, poll);
      send_pct = spct;
      rsp_pct = rpct;
      if (directed) add_directed();
      else while (stim_q.size() < budget) add_sequence(budget - stim_q.size());
      put(REQ_WRITE, $urandom, 16'd0, $urandom, $urandom);
      while (stim_q.size() != 0) send_item(stim_q.pop_front());
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_phase(1'b1, 1048576, 255, 0, 0, 0);
      run_phase(1'b0, 1, 1, 37, 67, 190);
      run_phase(1'b0, $urandom_range(64, 2), $urandom_range(16, 2), 67, 37, 190);
      run_phase(1'b0, $urandom_range(300, 3), $urandom_range(255, 3), 0, 0, 190);
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Drove %0d transactions in %0d command sequences under four register settings.",
               items_sent, sequences);
      $display("Response mismatches found: %0d.", mismatches);
      if (mismatches == 0) begin
         $display("[sd_card_spi_host_engine] OK");
      end else begin
         $display("[sd_card_spi_host_engine] ERROR");
      end
      $finish;
   end
endmodule
